FILE: rtl/slcd_pkg.sv
// Shared types, codes and constants for the serial LCD text writer.
package slcd_pkg;

    // Operation codes carried on the func field.
    typedef enum logic [1:0] {
        FUNC_CMD    = 2'd0,
        FUNC_DATA   = 2'd1,
        FUNC_CURSOR = 2'd2,
        FUNC_PAIR   = 2'd3
    } func_t;

    // Frame constants of the controller's serial protocol.
    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] NIBBLE_HI = 8'hF0;
    localparam logic [7:0] FUNC_SET  = 8'h30;

    // Byte positions inside one three-byte frame.
    localparam logic [1:0] POS_SYNC = 2'd0;
    localparam logic [1:0] POS_HIGH = 2'd1;
    localparam logic [1:0] POS_LOW  = 2'd2;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified item: up to three frames, each a data/command flag and a byte.
    typedef struct packed {
        logic [1:0]      last_frame;
        logic [2:0]      is_data;
        logic [2:0][7:0] bytes;
    } job_t;

    // DDRAM address base of each text row.
    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'h90;
            2'd2:    b = 8'h88;
            default: b = 8'h98;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/slcd_front.sv
// Front end: accepts items, keeps the text cursor and classifies items into frame jobs.
module slcd_front import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] value,
    input  logic [7:0] second_char,
    input  logic [1:0] row,
    input  logic [2:0] col,
    output logic       push_valid,
    input  logic       push_ready,
    output job_t       push_job
);

    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [3:0] cursor_col_reg, cursor_col_next;
    logic [1:0] eff_row;
    logic [3:0] eff_col;
    logic       accept;

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;

    // A full column wraps to the start of the next row before a pair is placed.
    always_comb
    begin
        if (cursor_col_reg[3])
        begin
            eff_col = 4'd0;
            eff_row = cursor_row_reg + 2'd1;
        end
        else
        begin
            eff_col = cursor_col_reg;
            eff_row = cursor_row_reg;
        end
    end

    // Classify the word and work out the cursor update.
    always_comb
    begin
        push_job        = '0;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        case (func_t'(func))
            FUNC_CMD:
            begin
                push_job.last_frame = 2'd0;
                push_job.bytes[0]   = value;
            end
            FUNC_DATA:
            begin
                push_job.last_frame = 2'd1 - 2'd1;
                push_job.is_data[0] = 1'b1;
                push_job.bytes[0]   = value;
            end
            FUNC_CURSOR:
            begin
                cursor_row_next     = row;
                cursor_col_next     = {1'b0, col};
                push_job.last_frame = 2'd1;
                push_job.bytes[0]   = FUNC_SET;
                push_job.bytes[1]   = row_base(row) + {5'd0, col};
            end
            FUNC_PAIR:
            begin
                cursor_row_next     = eff_row;
                cursor_col_next     = eff_col + 4'd1;
                push_job.last_frame = 2'd2;
                push_job.is_data    = 3'b110;
                push_job.bytes[0]   = row_base(eff_row) + {5'd0, eff_col[2:0]};
                push_job.bytes[1]   = value;
                push_job.bytes[2]   = second_char;
            end
            default:
            begin
                push_job = '0;
            end
        endcase
    end

    // Cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 2'd0;
            cursor_col_reg <= 4'd0;
        end
        else if (accept)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule

FILE: rtl/slcd_queue.sv
// Short job queue that decouples the front end from the byte emitter.
module slcd_queue import slcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/slcd_back.sv
// Back end: walks a job frame by frame and emits one frame byte per word.
module slcd_back import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  job_t       pop_job,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_end,
    output logic       last
);

    logic [1:0] frame_idx_reg;
    logic [1:0] byte_idx_reg;
    logic       out_valid_reg;
    logic [7:0] frame_byte_reg;
    logic       frame_end_reg;
    logic       last_reg;

    logic       load;
    logic [7:0] cur_byte;
    logic [7:0] byte_next;
    logic       end_next;
    logic       last_next;

    assign load = pop_valid && (!out_valid_reg || out_ready);

    // Select the byte for the current position in the frame.
    always_comb
    begin
        cur_byte = pop_job.bytes[frame_idx_reg];
        case (byte_idx_reg)
            POS_SYNC: byte_next = pop_job.is_data[frame_idx_reg] ? SYNC_DATA : SYNC_CMD;
            POS_HIGH: byte_next = cur_byte & NIBBLE_HI;
            POS_LOW:  byte_next = {cur_byte[3:0], 4'd0};
            default:  byte_next = 8'd0;
        endcase
        end_next  = (byte_idx_reg == POS_LOW);
        last_next = end_next && (frame_idx_reg == pop_job.last_frame);
    end

    // The job leaves the queue with its final byte.
    assign pop_ready = load && last_next;

    // Position counters and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_idx_reg <= 2'd0;
            byte_idx_reg  <= POS_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (last_next)
                begin
                    frame_idx_reg <= 2'd0;
                    byte_idx_reg  <= POS_SYNC;
                end
                else if (end_next)
                begin
                    frame_idx_reg <= frame_idx_reg + 2'd1;
                    byte_idx_reg  <= POS_SYNC;
                end
                else
                begin
                    byte_idx_reg <= byte_idx_reg + 2'd1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_byte_reg <= byte_next;
            frame_end_reg  <= end_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign frame_end  = frame_end_reg;
    assign last       = last_reg;

endmodule

FILE: rtl/serial_lcd_text_writer.sv
// Top level of the serial LCD text writer: front end, job queue and byte emitter.
//
// Input channel (in_valid/in_ready) takes one operation word: write command,
// write data, set cursor or put character pair. Output channel
// (out_valid/out_ready) gives one serial frame byte per word, with frame_end
// on the third byte of each frame and last on the final byte of an operation.
// An operation yields 3 bytes (command, data), 6 (set cursor) or 9 (pair).
// The first byte of an operation is written into a queue entry at the accepting
// edge and then registered into the emitter's output register once the emitter
// is free. The emitter produces one byte per cycle while out_ready stays high
// and the queue holds a job.
// The front end keeps the text cursor and accepts a new word whenever the job
// queue has room, so it keeps working while the receiver stalls; once the
// queue fills, in_ready drops until the emitter frees an entry.
// Reset clears the cursor to row 0, column 0, empties the queue and drops
// out_valid.
module serial_lcd_text_writer import slcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] value,
    input  logic [7:0] second_char,
    input  logic [1:0] row,
    input  logic [2:0] col,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_end,
    output logic       last
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Classification and cursor.
    slcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .second_char (second_char),
        .row         (row),
        .col         (col),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    // Job queue.
    slcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Byte emitter.
    slcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .last       (last)
    );

endmodule

FILE: bench/slcd_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the serial LCD text writer: predicts every frame byte and compares.
module slcd_frame_checker import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] value,
    input  logic [7:0] second_char,
    input  logic [1:0] row,
    input  logic [2:0] col,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       last,
    output int         mismatches,
    output int         pending
);

    // One serial byte as the block should emit it.
    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
        logic       flast;
    } frame_word_t;

    // DDRAM address base of each text row.
    localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    frame_word_t frames_due[$];
    logic [1:0]  cur_row;
    logic [3:0]  cur_col;

    // Appends the three bytes of one write frame to the expected stream.
    task automatic queue_frame(input logic [7:0] sync, input logic [7:0] b,
                               input logic closes_item);
        frames_due.push_back('{sync, 1'b0, 1'b0});
        frames_due.push_back('{b & NIBBLE_HI, 1'b0, 1'b0});
        frames_due.push_back('{(b << 4) & NIBBLE_HI, 1'b1, closes_item});
    endtask

    // Compare each delivered byte, then predict the bytes of each accepted word.
    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_word_t got;
        frame_word_t want;
        logic [7:0]  addr;
        if (!rst_n)
        begin
            frames_due.delete();
            cur_row    = 2'd0;
            cur_col    = 4'd0;
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // A byte leaving the block must match the oldest prediction.
            if (out_valid && out_ready)
            begin
                got = '{frame_byte, frame_end, last};
                if (frames_due.size() == 0)
                begin
                    $display("%0t ns: byte with nothing expected: byte=%h end=%b last=%b",
                             $time, frame_byte, frame_end, last);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t ns: expected byte=%h end=%b last=%b, got byte=%h end=%b last=%b",
                                 $time, want.fbyte, want.fend, want.flast,
                                 got.fbyte, got.fend, got.flast);
                        mismatches++;
                    end
                end
            end

            // An accepted word updates the cursor and yields its frames.
            if (in_valid && in_ready)
            begin
                case (func_t'(func))
                    FUNC_CMD:
                    begin
                        queue_frame(SYNC_CMD, value, 1'b1);
                    end
                    FUNC_DATA:
                    begin
                        queue_frame(SYNC_DATA, value, 1'b1);
                    end
                    FUNC_CURSOR:
                    begin
                        cur_row = row;
                        cur_col = {1'b0, col};
                        addr    = ROW_ADDR[cur_row] + {5'd0, cur_col[2:0]};
                        queue_frame(SYNC_CMD, FUNC_SET, 1'b0);
                        queue_frame(SYNC_CMD, addr, 1'b1);
                    end
                    default:
                    begin
                        // A full column wraps to the start of the next row.
                        if (cur_col >= 4'd8)
                        begin
                            cur_col = 4'd0;
                            cur_row = cur_row + 2'd1;
                        end
                        addr = ROW_ADDR[cur_row] + {5'd0, cur_col[2:0]};
                        queue_frame(SYNC_CMD, addr, 1'b0);
                        queue_frame(SYNC_DATA, value, 1'b0);
                        queue_frame(SYNC_DATA, second_char, 1'b1);
                        cur_col = cur_col + 4'd1;
                    end
                endcase
            end
            pending = frames_due.size();
        end
    end

endmodule

FILE: bench/serial_lcd_text_writer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the serial LCD text writer: clock, reset, stimulus and verdict.
module serial_lcd_text_writer_tb;
    import slcd_pkg::*;

    localparam int RANDOM_WORDS = 200;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       out_ready   = 1'b0;
    func_t      func        = FUNC_CMD;
    logic [7:0] value       = 8'd0;
    logic [7:0] second_char = 8'd0;
    logic [1:0] row         = 2'd0;
    logic [2:0] col         = 3'd0;
    logic       calm        = 1'b0;
    int         stall_cycles = 0;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last;
    int         mismatches;
    int         pending;

    serial_lcd_text_writer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .second_char (second_char),
        .row         (row),
        .col         (col),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .last        (last)
    );

    slcd_frame_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .second_char (second_char),
        .row         (row),
        .col         (col),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .last        (last),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The receiver stalls about one cycle in five, except in the calm stretch.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 21);
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(input func_t f, input logic [7:0] v, input logic [7:0] s,
                             input logic [1:0] r, input logic [2:0] c);
        logic taken;
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        value       <= v;
        second_char <= s;
        row         <= r;
        col         <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted byte has been delivered.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int    sel;
        func_t op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: byte extremes, every operation, full column and row wrap.
        send_word(FUNC_CMD,    8'h00, 8'hFF, 2'd3, 3'd7);
        send_word(FUNC_CMD,    8'hFF, 8'h00, 2'd0, 3'd0);
        send_word(FUNC_DATA,   8'h00, 8'h00, 2'd0, 3'd0);
        send_word(FUNC_DATA,   8'hFF, 8'hFF, 2'd3, 3'd7);
        send_word(FUNC_DATA,   8'hA5, 8'h5A, 2'd1, 3'd2);
        send_word(FUNC_PAIR,   8'h41, 8'h42, 2'd2, 3'd5);
        send_word(FUNC_CURSOR, 8'h00, 8'h00, 2'd0, 3'd0);
        send_word(FUNC_CURSOR, 8'hFF, 8'hFF, 2'd1, 3'd3);
        send_word(FUNC_CURSOR, 8'h12, 8'h34, 2'd2, 3'd5);
        send_word(FUNC_CURSOR, 8'h00, 8'h00, 2'd3, 3'd7);
        send_word(FUNC_PAIR,   8'h00, 8'hFF, 2'd0, 3'd0);
        send_word(FUNC_PAIR,   8'hFF, 8'h00, 2'd1, 3'd1);
        send_word(FUNC_PAIR,   8'h5A, 8'hA5, 2'd2, 3'd2);
        send_word(FUNC_CURSOR, 8'h00, 8'h00, 2'd2, 3'd6);
        send_word(FUNC_PAIR,   8'h31, 8'h32, 2'd0, 3'd0);
        send_word(FUNC_PAIR,   8'h33, 8'h34, 2'd0, 3'd0);
        send_word(FUNC_PAIR,   8'h35, 8'h36, 2'd0, 3'd0);
        send_word(FUNC_CURSOR, 8'h00, 8'h00, 2'd0, 3'd0);
        for (int k = 0; k < 7; k++)
            send_word(FUNC_PAIR, 8'(8'h61 + k), 8'(8'h71 + k), 2'd0, 3'd0);

        // Random words, mostly character pairs so the cursor keeps wrapping.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 80 && i < 130);
            if (i == 150)
                wait_drained();
            sel = $urandom_range(99);
            if (sel < 50)
                op = FUNC_PAIR;
            else if (sel < 65)
                op = FUNC_CURSOR;
            else if (sel < 80)
                op = FUNC_CMD;
            else
                op = FUNC_DATA;
            send_word(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      2'($urandom_range(3)), 3'($urandom_range(7)));
        end

        // Let every predicted byte arrive, then a short quiet tail.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/slcd_pkg.sv
rtl/slcd_front.sv
rtl/slcd_queue.sv
rtl/slcd_back.sv
rtl/serial_lcd_text_writer.sv
bench/slcd_frame_checker.sv
bench/serial_lcd_text_writer_tb.sv
